### rtl/core/load_expensive_join_detector_top_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the load / expensive join detector
// Shared concurrent-assertion shorthands, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LOAD_EXPENSIVE_JOIN_DETECTOR_TOP_ASSERT_SVH
`define LOAD_EXPENSIVE_JOIN_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication
`define LJD_ASSERT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication
`define LJD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/ljd_pkg.sv
// ----------------------------------------------------------------------------
// ljd_pkg
// Types, opcode constants and decode helpers for the load / expensive join
// detector.
// ----------------------------------------------------------------------------
`default_nettype none

package ljd_pkg;

	localparam int REG_W    = 5;
	localparam int NUM_REGS = 2 ** REG_W;

	// Major opcodes
	localparam logic [6:0] OPC_LOAD  = 7'h03;
	localparam logic [6:0] OPC_STORE = 7'h23;
	localparam logic [6:0] OPC_OP    = 7'h33;
	localparam logic [6:0] OPC_OP32  = 7'h3B;
	localparam logic [6:0] OPC_IMM   = 7'h13;
	localparam logic [6:0] OPC_IMM32 = 7'h1B;

	typedef logic [REG_W-1:0] reg_idx_t;

	typedef enum logic [1:0] {
		CLS_NONE  = 2'd0,
		CLS_LOAD  = 2'd1,
		CLS_EXP   = 2'd2,
		CLS_OTHER = 2'd3
	} ljd_cls_t;

	// Input transaction
	typedef struct packed {
		logic [63:0] instr_pc;
		logic [15:0] inst_code;
		logic [31:0] raw_word;
		logic        is_full_width;
		logic        is_load;
		logic        is_mem_write;
		logic        is_expensive;
	} ljd_in_t;

	// Result transaction
	typedef struct packed {
		logic        chain_found;
		logic [63:0] seq_number;
		logic [63:0] load_pc;
		logic [63:0] exp_pc;
		logic [15:0] load_kind;
		logic [15:0] exp_kind;
		logic [14:0] load_regs;
		logic [14:0] exp_regs;
		logic [63:0] long_count;
		logic [63:0] exp_count;
	} ljd_out_t;

	// Producer register fields, 17 bits
	typedef struct packed {
		reg_idx_t rd;
		logic     v1;
		reg_idx_t rs1;
		logic     v2;
		reg_idx_t rs2;
	} ljd_fields_t;

	typedef struct packed {
		logic [63:0] pc;
		logic [15:0] kind;
		ljd_fields_t fields;
	} ljd_prod_t;

	typedef struct packed {
		ljd_cls_t  cls;
		ljd_prod_t prod;
	} ljd_entry_t;

	// Decoded register usage of one instruction
	typedef struct packed {
		reg_idx_t rd;
		reg_idx_t rs1;
		reg_idx_t rs2;
		logic     h1;
		logic     h2;
		logic     wr;
		logic     rr_op;
	} ljd_dec_t;

	// Table read and write requests
	typedef struct packed {
		logic     en;
		reg_idx_t addr_a;
		reg_idx_t addr_b;
	} ljd_rd_t;

	typedef struct packed {
		logic       en;
		reg_idx_t   addr;
		ljd_entry_t entry;
	} ljd_wr_t;

	// Decode rd, rs1, rs2 by major opcode; compressed words decode nothing
	function automatic ljd_dec_t ljd_decode(logic [31:0] raw, logic full);
		ljd_dec_t d;
		d = '0;
		if (full) begin
			case (raw[6:0])
				OPC_LOAD, OPC_IMM, OPC_IMM32: begin
					d.rd  = raw[11:7];
					d.rs1 = raw[19:15];
					d.wr  = 1'b1;
					d.h1  = 1'b1;
				end
				OPC_STORE: begin
					d.rs1 = raw[19:15];
					d.rs2 = raw[24:20];
					d.h1  = 1'b1;
					d.h2  = 1'b1;
				end
				OPC_OP, OPC_OP32: begin
					d.rd    = raw[11:7];
					d.rs1   = raw[19:15];
					d.rs2   = raw[24:20];
					d.wr    = 1'b1;
					d.h1    = 1'b1;
					d.h2    = 1'b1;
					d.rr_op = 1'b1;
				end
				default: begin
					d = '0;
				end
			endcase
		end
		return d;
	endfunction

	// True when r is a valid source of f
	function automatic logic ljd_reads(ljd_fields_t f, reg_idx_t r);
		return (f.v1 && f.rs1 == r) || (f.v2 && f.rs2 == r);
	endfunction

	// Pack rd, rs1, rs2 for the report; absent sources read zero
	function automatic logic [14:0] ljd_report(ljd_fields_t f);
		reg_idx_t r1;
		reg_idx_t r2;
		r1 = f.v1 ? f.rs1 : '0;
		r2 = f.v2 ? f.rs2 : '0;
		return {f.rd, r1, r2};
	endfunction

endpackage

`default_nettype wire

### rtl/core/ljd_table.sv
// ----------------------------------------------------------------------------
// ljd_table
// Last-producer table: class flops cleared at reset, producer payload memory,
// two registered read ports with write-through on a same-edge write.
// ----------------------------------------------------------------------------
`default_nettype none

module ljd_table import ljd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  ljd_rd_t    rd,
	input  ljd_wr_t    wr,
	output ljd_entry_t rd_data_a,
	output ljd_entry_t rd_data_b
);

	ljd_cls_t   cls_q [NUM_REGS];
	ljd_prod_t  prod_mem [NUM_REGS];
	ljd_entry_t data_a_q;
	ljd_entry_t data_b_q;

	// Class per register, cleared to no producer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cls_q[i] <= CLS_NONE;
			end
		end else if (wr.en) begin
			cls_q[wr.addr] <= wr.entry.cls;
		end
	end

	// Producer payload, undefined until written
	always_ff @(posedge clk) begin
		if (wr.en) begin
			prod_mem[wr.addr] <= wr.entry.prod;
		end
	end

	// Read both sources; forward a write landing on the same edge
	always_ff @(posedge clk) begin
		if (rd.en) begin
			if (wr.en && wr.addr == rd.addr_a) begin
				data_a_q <= wr.entry;
			end else begin
				data_a_q.cls  <= cls_q[rd.addr_a];
				data_a_q.prod <= prod_mem[rd.addr_a];
			end
			if (wr.en && wr.addr == rd.addr_b) begin
				data_b_q <= wr.entry;
			end else begin
				data_b_q.cls  <= cls_q[rd.addr_b];
				data_b_q.prod <= prod_mem[rd.addr_b];
			end
		end
	end

	assign rd_data_a = data_a_q;
	assign rd_data_b = data_b_q;

endmodule

`default_nettype wire

### rtl/core/load_expensive_join_detector_top.sv
// ----------------------------------------------------------------------------
// load_expensive_join_detector_top
// Tracks the last producer of each register over a retired-instruction stream
// and reports register-register instructions that join a load result with an
// independent multiply/divide result, along with running counts.
//
//   channel   handshake                    payload
//   item      item_valid / item_ready      item   (ljd_in_t)
//   result    result_valid / result_ready  result (ljd_out_t)
//
// One transaction per cycle while results are taken; result valid rises after
// the item passes stage 1 (table read into stage 1, then the result register).
// The table read at acceptance and the write as stage 1 retires share an
// edge; write-through in the table keeps back-to-back dependences exact.
// arst_n clears the producer classes, counters and valid flags at once.
// A stalled result holds stage 1, which still accepts into the result slot
// as soon as it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module load_expensive_join_detector_top import ljd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	output logic     item_ready,
	input  ljd_in_t  item,
	output logic     result_valid,
	input  logic     result_ready,
	output ljd_out_t result
);

	ljd_dec_t    dec_in;
	logic        item_fire;
	logic        adv;

	logic        valid_s1;
	logic [63:0] pc_s1;
	logic [15:0] kind_s1;
	ljd_dec_t    dec_s1;
	logic        ld_s1;
	logic        st_s1;
	logic        ex_s1;

	ljd_rd_t     tbl_rd;
	ljd_wr_t     tbl_wr;
	ljd_entry_t  ent_a;
	ljd_entry_t  ent_b;

	logic [63:0] seq_q;
	logic [63:0] long_q;
	logic [63:0] exp_q;
	logic [63:0] seq_d;
	logic [63:0] long_d;
	logic [63:0] exp_d;

	ljd_entry_t  l_ent;
	ljd_entry_t  e_ent;
	logic        hit;
	logic        indep;
	ljd_out_t    res_d;
	ljd_out_t    res_q;
	logic        result_valid_q;

	// Handshake
	assign adv        = valid_s1 && (!result_valid_q || result_ready);
	assign item_ready = !valid_s1 || adv;
	assign item_fire  = item_valid && item_ready;

	// Decode at the port to address the table
	assign dec_in = ljd_decode(item.raw_word, item.is_full_width);

	assign tbl_rd.en     = item_fire;
	assign tbl_rd.addr_a = dec_in.rs1;
	assign tbl_rd.addr_b = dec_in.rs2;

	// Stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_fire) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	// Stage 1 payload
	always_ff @(posedge clk) begin
		if (item_fire) begin
			pc_s1   <= item.instr_pc;
			kind_s1 <= item.inst_code;
			dec_s1  <= dec_in;
			ld_s1   <= item.is_load;
			st_s1   <= item.is_mem_write;
			ex_s1   <= item.is_expensive;
		end
	end

	ljd_table u_table (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (tbl_rd),
		.wr        (tbl_wr),
		.rd_data_a (ent_a),
		.rd_data_b (ent_b)
	);

	// Record this instruction as the producer of rd, never x0
	always_comb begin
		tbl_wr.en                    = adv && dec_s1.wr && (dec_s1.rd != '0);
		tbl_wr.addr                  = dec_s1.rd;
		tbl_wr.entry.cls             = ld_s1 ? CLS_LOAD : (ex_s1 ? CLS_EXP : CLS_OTHER);
		tbl_wr.entry.prod.pc         = pc_s1;
		tbl_wr.entry.prod.kind       = kind_s1;
		tbl_wr.entry.prod.fields.rd  = dec_s1.rd;
		tbl_wr.entry.prod.fields.v1  = dec_s1.h1;
		tbl_wr.entry.prod.fields.rs1 = dec_s1.h1 ? dec_s1.rs1 : '0;
		tbl_wr.entry.prod.fields.v2  = dec_s1.h2;
		tbl_wr.entry.prod.fields.rs2 = dec_s1.h2 ? dec_s1.rs2 : '0;
	end

	// Running counts including this instruction
	assign seq_d  = seq_q + 64'd1;
	assign long_d = long_q + {63'd0, ld_s1 | st_s1};
	assign exp_d  = exp_q + {63'd0, ex_s1};

	// Pick load and expensive producers, check independence, build report
	always_comb begin
		hit   = 1'b0;
		l_ent = ent_a;
		e_ent = ent_b;
		if (ent_a.cls == CLS_LOAD && ent_b.cls == CLS_EXP) begin
			hit = 1'b1;
		end else if (ent_b.cls == CLS_LOAD && ent_a.cls == CLS_EXP) begin
			hit   = 1'b1;
			l_ent = ent_b;
			e_ent = ent_a;
		end
		indep = !ljd_reads(e_ent.prod.fields, l_ent.prod.fields.rd)
			&& !ljd_reads(l_ent.prod.fields, e_ent.prod.fields.rd);

		res_d = '0;
		if (dec_s1.rr_op && hit && indep) begin
			res_d.chain_found = 1'b1;
			res_d.load_pc     = l_ent.prod.pc;
			res_d.exp_pc      = e_ent.prod.pc;
			res_d.load_kind   = l_ent.prod.kind;
			res_d.exp_kind    = e_ent.prod.kind;
			res_d.load_regs   = ljd_report(l_ent.prod.fields);
			res_d.exp_regs    = ljd_report(e_ent.prod.fields);
		end
		res_d.seq_number = seq_d;
		res_d.long_count = long_d;
		res_d.exp_count  = exp_d;
	end

	// Counters advance as each transaction leaves stage 1
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= '0;
			long_q <= '0;
			exp_q  <= '0;
		end else if (adv) begin
			seq_q  <= seq_d;
			long_q <= long_d;
			exp_q  <= exp_d;
		end
	end

	// Result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	// Result register payload
	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = res_q;

endmodule

`default_nettype wire

### rtl/core/ljd_checker.sv
// ----------------------------------------------------------------------------
// ljd_checker
// Port-level checks on the result channel of the join detector, bound to the
// top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "load_expensive_join_detector_top_assert.svh"

module ljd_checker import ljd_pkg::*; (
	input logic     clk,
	input logic     arst_n,
	input logic     result_valid,
	input logic     result_ready,
	input ljd_out_t result
);

	logic        seen_q;
	logic [63:0] last_seq_q;
	logic [63:0] last_long_q;
	logic [63:0] last_exp_q;
	logic        no_report;

	// Track the last delivered counts
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q      <= 1'b0;
			last_seq_q  <= '0;
			last_long_q <= '0;
			last_exp_q  <= '0;
		end else if (result_valid && result_ready) begin
			seen_q      <= 1'b1;
			last_seq_q  <= result.seq_number;
			last_long_q <= result.long_count;
			last_exp_q  <= result.exp_count;
		end
	end

	assign no_report = (result.load_pc == 64'd0) && (result.exp_pc == 64'd0)
		&& (result.load_kind == 16'd0) && (result.exp_kind == 16'd0)
		&& (result.load_regs == 15'd0) && (result.exp_regs == 15'd0);

	`LJD_ASSERT_NEXT(a_result_hold, result_valid && !result_ready,
		result_valid && $stable(result), "result changed while stalled")

	`LJD_ASSERT(a_seq_first, result_valid && !seen_q,
		result.seq_number == 64'd1, "first result after reset not sequence one")

	`LJD_ASSERT(a_seq_step, result_valid && seen_q,
		result.seq_number == last_seq_q + 64'd1, "sequence number skipped or repeated")

	`LJD_ASSERT(a_count_step, result_valid && seen_q,
		((result.long_count - last_long_q) <= 64'd1)
		&& ((result.exp_count - last_exp_q) <= 64'd1), "count moved by more than one")

	`LJD_ASSERT(a_no_chain_zero, result_valid && !result.chain_found,
		no_report, "report fields nonzero without a chain")

endmodule

bind load_expensive_join_detector_top ljd_checker u_ljd_checker (.*);

`default_nettype wire

### sim/ljd_join_checker.sv
// ----------------------------------------------------------------------------
// ljd_join_checker
// Watches both channels of the join detector. It tracks the last producer of
// every register on its own, predicts each result as an instruction is
// accepted and compares each accepted result with the oldest prediction.
// ----------------------------------------------------------------------------
module ljd_join_checker import ljd_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     item_ready,
	input  ljd_in_t  item,
	input  logic     result_valid,
	input  logic     result_ready,
	input  ljd_out_t result,
	output int       fail_count,
	output int       pending,
	output int       results_seen,
	output int       chains_seen
);

	// Shadow producer table and running counts
	ljd_cls_t    owner_cls    [NUM_REGS];
	logic [63:0] owner_pc     [NUM_REGS];
	logic [15:0] owner_tag    [NUM_REGS];
	ljd_fields_t owner_fields [NUM_REGS];
	logic [63:0] seq_total;
	logic [63:0] mem_total;
	logic [63:0] heavy_total;

	ljd_out_t expected_results [$];
	ljd_out_t oldest;
	ljd_out_t predicted;

	initial begin
		for (int i = 0; i < NUM_REGS; i++) begin
			owner_cls[i]    = CLS_NONE;
			owner_pc[i]     = '0;
			owner_tag[i]    = '0;
			owner_fields[i] = '0;
		end
		seq_total    = '0;
		mem_total    = '0;
		heavy_total  = '0;
		fail_count   = 0;
		pending      = 0;
		results_seen = 0;
		chains_seen  = 0;
	end

	// True when register r is a live source of producer fields f
	function automatic logic src_uses(ljd_fields_t f, reg_idx_t r);
		return (f.v1 && (f.rs1 == r)) || (f.v2 && (f.rs2 == r));
	endfunction

	// rd, rs1, rs2 of a producer as reported; missing sources show as zero
	function automatic logic [14:0] pack_regs(ljd_fields_t f);
		return {f.rd, (f.v1 ? f.rs1 : 5'd0), (f.v2 ? f.rs2 : 5'd0)};
	endfunction

	// Work out the report of one instruction and update the shadow table
	task automatic predict_join(input ljd_in_t it, output ljd_out_t res);
		reg_idx_t    rd;
		reg_idx_t    rs1;
		reg_idx_t    rs2;
		logic        has1;
		logic        has2;
		logic        writes;
		logic        joins;
		ljd_cls_t    c1;
		ljd_cls_t    c2;
		reg_idx_t    li;
		reg_idx_t    ei;
		logic        hit;
		ljd_fields_t fl;
		ljd_fields_t fe;
		ljd_fields_t fnew;
		rd     = '0;
		rs1    = '0;
		rs2    = '0;
		has1   = 1'b0;
		has2   = 1'b0;
		writes = 1'b0;
		joins  = 1'b0;
		li     = '0;
		ei     = '0;
		hit    = 1'b0;
		res    = '0;

		// Decode by major opcode; compressed words decode nothing
		if (it.is_full_width) begin
			case (it.raw_word[6:0])
				OPC_LOAD, OPC_IMM, OPC_IMM32: begin
					rd     = it.raw_word[11:7];
					rs1    = it.raw_word[19:15];
					writes = 1'b1;
					has1   = 1'b1;
				end
				OPC_STORE: begin
					rs1  = it.raw_word[19:15];
					rs2  = it.raw_word[24:20];
					has1 = 1'b1;
					has2 = 1'b1;
				end
				OPC_OP, OPC_OP32: begin
					rd     = it.raw_word[11:7];
					rs1    = it.raw_word[19:15];
					rs2    = it.raw_word[24:20];
					writes = 1'b1;
					has1   = 1'b1;
					has2   = 1'b1;
					joins  = 1'b1;
				end
				default: begin
				end
			endcase
		end

		seq_total = seq_total + 64'd1;
		if (it.is_load || it.is_mem_write)
			mem_total = mem_total + 64'd1;
		if (it.is_expensive)
			heavy_total = heavy_total + 64'd1;

		// Look for a load source joined with an independent expensive one
		if (joins) begin
			c1 = owner_cls[rs1];
			c2 = owner_cls[rs2];
			if (c1 == CLS_LOAD && c2 == CLS_EXP) begin
				li  = rs1;
				ei  = rs2;
				hit = 1'b1;
			end else if (c2 == CLS_LOAD && c1 == CLS_EXP) begin
				li  = rs2;
				ei  = rs1;
				hit = 1'b1;
			end
			if (hit) begin
				fl = owner_fields[li];
				fe = owner_fields[ei];
				if (!src_uses(fe, fl.rd) && !src_uses(fl, fe.rd)) begin
					res.chain_found = 1'b1;
					res.load_pc     = owner_pc[li];
					res.exp_pc      = owner_pc[ei];
					res.load_kind   = owner_tag[li];
					res.exp_kind    = owner_tag[ei];
					res.load_regs   = pack_regs(fl);
					res.exp_regs    = pack_regs(fe);
				end
			end
		end
		res.seq_number = seq_total;
		res.long_count = mem_total;
		res.exp_count  = heavy_total;

		// Record the producer; x0 is never recorded
		if (writes && rd != '0) begin
			fnew.rd  = rd;
			fnew.v1  = has1;
			fnew.rs1 = has1 ? rs1 : 5'd0;
			fnew.v2  = has2;
			fnew.rs2 = has2 ? rs2 : 5'd0;
			if (it.is_load)
				owner_cls[rd] = CLS_LOAD;
			else if (it.is_expensive)
				owner_cls[rd] = CLS_EXP;
			else
				owner_cls[rd] = CLS_OTHER;
			owner_pc[rd]     = it.instr_pc;
			owner_tag[rd]    = it.inst_code;
			owner_fields[rd] = fnew;
		end
	endtask

	task automatic check_field(input string name, input logic [63:0] want_v,
			input logic [63:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0h, actual %0h", name, want_v, got_v);
			fail_count++;
		end
	endtask

	// Compare accepted results, then queue the prediction of an accepted item
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result transaction with no instruction outstanding");
					fail_count++;
				end else begin
					oldest = expected_results.pop_front();
					if (oldest.chain_found)
						chains_seen++;
					check_field("chain_found", 64'(oldest.chain_found), 64'(result.chain_found));
					check_field("seq_number", oldest.seq_number, result.seq_number);
					check_field("load_pc", oldest.load_pc, result.load_pc);
					check_field("exp_pc", oldest.exp_pc, result.exp_pc);
					check_field("load_kind", 64'(oldest.load_kind), 64'(result.load_kind));
					check_field("exp_kind", 64'(oldest.exp_kind), 64'(result.exp_kind));
					check_field("load_regs", 64'(oldest.load_regs), 64'(result.load_regs));
					check_field("exp_regs", 64'(oldest.exp_regs), 64'(result.exp_regs));
					check_field("long_count", oldest.long_count, result.long_count);
					check_field("exp_count", oldest.exp_count, result.exp_count);
				end
			end
			if (item_valid && item_ready) begin
				predict_join(item, predicted);
				expected_results.push_back(predicted);
			end
			pending = expected_results.size();
		end
	end

endmodule

### sim/tb_load_expensive_join_detector_top.sv
// ----------------------------------------------------------------------------
// tb_load_expensive_join_detector_top
// Drives retired instructions into the join detector: a directed set of load,
// expensive and join cases, then mostly load / expensive / join sequences with
// random content mixed with random single instructions. Both sides idle at
// random; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_load_expensive_join_detector_top;
	import ljd_pkg::*;

	localparam int RANDOM_ITEMS = 950;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int HOLD_CYCLES  = 80;

	logic     clk;
	logic     arst_n;
	logic     item_valid;
	logic     item_ready;
	ljd_in_t  item;
	logic     result_valid;
	logic     result_ready;
	ljd_out_t result;

	int fail_count;
	int pending;
	int results_seen;
	int chains_seen;
	int items_sent;
	int cycles;
	logic steady;
	logic hold_request;

	load_expensive_join_detector_top dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	ljd_join_checker checker_i (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.fail_count   (fail_count),
		.pending      (pending),
		.results_seen (results_seen),
		.chains_seen  (chains_seen)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run
	initial begin
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run exceeded %0d cycles", CYCLE_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// Receiver: random back-pressure, plus long hold-offs on request
	initial begin
		result_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_request) begin
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_request = 1'b0;
			end else begin
				result_ready <= steady || ($urandom_range(99) >= 27);
			end
		end
	end

	// Mostly low registers, so producers get reused
	function automatic reg_idx_t pick_reg();
		if ($urandom_range(9) < 7)
			return reg_idx_t'($urandom_range(7));
		return reg_idx_t'($urandom_range(31));
	endfunction

	// Full-width instruction with random pc, tag, funct3 and funct7
	function automatic ljd_in_t make_item(logic [6:0] opc, reg_idx_t rd, reg_idx_t rs1,
			reg_idx_t rs2, logic ld, logic st, logic ex);
		ljd_in_t it;
		it.instr_pc      = {$urandom, $urandom};
		it.inst_code     = 16'($urandom);
		it.raw_word      = {7'($urandom), rs2, rs1, 3'($urandom), rd, opc};
		it.is_full_width = 1'b1;
		it.is_load       = ld;
		it.is_mem_write  = st;
		it.is_expensive  = ex;
		return it;
	endfunction

	// Offer one transaction and hold it until accepted; called at a falling edge
	task automatic send_item(input ljd_in_t it);
		while (!steady && $urandom_range(99) < 27) begin
			item_valid <= 1'b0;
			@(negedge clk);
		end
		item_valid <= 1'b1;
		item       <= it;
		@(posedge clk);
		while (!item_ready)
			@(posedge clk);
		items_sent++;
		@(negedge clk);
	endtask

	// Drop valid and wait until every outstanding result has come back
	task automatic drain_results();
		item_valid <= 1'b0;
		do
			@(negedge clk);
		while (pending != 0);
	endtask

	// Load, expensive producer, then a join; some shapes break independence
	task automatic send_chain();
		reg_idx_t a;
		reg_idx_t b;
		int       shape;
		logic     swap;
		a     = pick_reg();
		b     = pick_reg();
		shape = $urandom_range(9);
		swap  = 1'($urandom);
		send_item(make_item(OPC_LOAD, a, (shape == 2) ? b : pick_reg(), pick_reg(),
			1'b1, 1'($urandom_range(3) == 0), 1'($urandom_range(3) == 0)));
		send_item(make_item(($urandom_range(3) == 0) ? OPC_IMM32 : OPC_OP, b,
			(shape == 0) ? a : pick_reg(), pick_reg(), 1'b0, 1'b0, 1'b1));
		if (shape == 1)
			send_item(make_item(OPC_IMM, pick_reg(), pick_reg(), pick_reg(),
				1'b0, 1'b0, 1'b0));
		send_item(make_item(($urandom_range(1) == 0) ? OPC_OP : OPC_OP32, pick_reg(),
			swap ? b : a, swap ? a : b, 1'b0, 1'b0, 1'($urandom_range(4) == 0)));
	endtask

	// Any single instruction, flags independent of the opcode
	task automatic send_single();
		ljd_in_t    it;
		logic [6:0] opc;
		case ($urandom_range(6))
			0: opc = OPC_LOAD;
			1: opc = OPC_STORE;
			2: opc = OPC_OP;
			3: opc = OPC_OP32;
			4: opc = OPC_IMM;
			5: opc = OPC_IMM32;
			default: opc = 7'($urandom);
		endcase
		it = make_item(opc, pick_reg(), pick_reg(), pick_reg(),
			1'($urandom_range(99) < 30), 1'($urandom_range(99) < 20),
			1'($urandom_range(99) < 30));
		if ($urandom_range(9) == 0) begin
			it.is_full_width = 1'b0;
			it.raw_word      = $urandom;
		end
		send_item(it);
	endtask

	initial begin
		ljd_in_t it;
		arst_n       = 1'b0;
		item_valid   = 1'b0;
		item         = '0;
		steady       = 1'b0;
		hold_request = 1'b0;
		items_sent   = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Compressed word decodes nothing, but still counts
		it = make_item(OPC_LOAD, 5'd5, 5'd1, 5'd2, 1'b1, 1'b0, 1'b0);
		it.is_full_width = 1'b0;
		send_item(it);
		// Load with all-ones pc and tag, then a multiply
		it = make_item(OPC_LOAD, 5'd5, 5'd1, 5'd0, 1'b1, 1'b0, 1'b0);
		it.instr_pc  = '1;
		it.inst_code = '1;
		send_item(it);
		send_item(make_item(OPC_OP, 5'd6, 5'd1, 5'd2, 1'b0, 1'b0, 1'b1));
		// Join in both source orders
		send_item(make_item(OPC_OP, 5'd7, 5'd5, 5'd6, 1'b0, 1'b0, 1'b0));
		send_item(make_item(OPC_OP32, 5'd8, 5'd6, 5'd5, 1'b0, 1'b0, 1'b0));
		// Same source twice
		send_item(make_item(OPC_OP, 5'd9, 5'd5, 5'd5, 1'b0, 1'b0, 1'b0));
		// Load reading the expensive result: not independent
		send_item(make_item(OPC_LOAD, 5'd10, 5'd6, 5'd3, 1'b1, 1'b0, 1'b0));
		send_item(make_item(OPC_OP, 5'd11, 5'd10, 5'd6, 1'b0, 1'b0, 1'b0));
		// Divide reading the load result: not independent
		send_item(make_item(OPC_OP, 5'd12, 5'd5, 5'd4, 1'b0, 1'b0, 1'b1));
		send_item(make_item(OPC_OP, 5'd13, 5'd5, 5'd12, 1'b0, 1'b0, 1'b0));
		// Load into x0 is not recorded
		send_item(make_item(OPC_LOAD, 5'd0, 5'd1, 5'd0, 1'b1, 1'b0, 1'b0));
		send_item(make_item(OPC_OP, 5'd14, 5'd0, 5'd6, 1'b0, 1'b0, 1'b0));
		// Store reads but writes nothing
		send_item(make_item(OPC_STORE, 5'd6, 5'd5, 5'd6, 1'b0, 1'b1, 1'b0));
		// Expensive flag on an immediate op, joined by a word op
		send_item(make_item(OPC_IMM, 5'd15, 5'd5, 5'd9, 1'b0, 1'b0, 1'b1));
		send_item(make_item(OPC_OP32, 5'd16, 5'd15, 5'd5, 1'b0, 1'b0, 1'b0));
		// Load and expensive both set: load wins
		send_item(make_item(OPC_IMM32, 5'd17, 5'd2, 5'd0, 1'b1, 1'b1, 1'b1));
		send_item(make_item(OPC_OP, 5'd18, 5'd17, 5'd6, 1'b0, 1'b0, 1'b0));
		// Unknown opcode neither joins nor writes
		send_item(make_item(7'h7F, 5'd5, 5'd6, 5'd7, 1'b0, 1'b1, 1'b1));
		send_item(make_item(OPC_OP, 5'd19, 5'd5, 5'd6, 1'b0, 1'b0, 1'b0));
		// Plain op overwrites the load producer
		send_item(make_item(OPC_OP, 5'd5, 5'd1, 5'd2, 1'b0, 1'b0, 1'b0));
		send_item(make_item(OPC_OP, 5'd20, 5'd5, 5'd6, 1'b0, 1'b0, 1'b0));
		// Highest registers, zero pc and tag on the join
		send_item(make_item(OPC_LOAD, 5'd31, 5'd31, 5'd0, 1'b1, 1'b0, 1'b0));
		send_item(make_item(OPC_OP, 5'd30, 5'd29, 5'd28, 1'b0, 1'b0, 1'b1));
		it = make_item(OPC_OP, 5'd29, 5'd30, 5'd31, 1'b0, 1'b0, 1'b0);
		it.instr_pc  = '0;
		it.inst_code = '0;
		send_item(it);
		drain_results();

		// Random part: phases with no idling, long hold-offs and full drains
		while (items_sent < RANDOM_ITEMS + 25) begin
			steady = (items_sent > 300 && items_sent < 450);
			if (items_sent > 600 && items_sent < 605)
				hold_request = 1'b1;
			if (items_sent > 800 && items_sent < 805)
				drain_results();
			if ($urandom_range(99) < 60)
				send_chain();
			else
				send_single();
		end
		steady = 1'b0;
		drain_results();
		repeat (20) @(negedge clk);

		$display("Sent %0d instructions; checked %0d results, %0d of them chains",
			items_sent, results_seen, chains_seen);
		$display("Covered joins, dependent pairs, x0, compressed and unknown words, stalls");
		if (fail_count == 0 && pending == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/ljd_pkg.sv
rtl/core/ljd_table.sv
rtl/core/load_expensive_join_detector_top.sv
rtl/core/ljd_checker.sv
sim/ljd_join_checker.sv
sim/tb_load_expensive_join_detector_top.sv
